[sv/capture_period_speed_meter_core_assert.svh]
// ----------------------------------------------------------------------------
// Capture period speed meter: assertion macros
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CAPTURE_PERIOD_SPEED_METER_CORE_ASSERT_SVH
`define CAPTURE_PERIOD_SPEED_METER_CORE_ASSERT_SVH

// same-cycle implication
`define CPSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CPSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/cpsm_pkg.sv]
// ----------------------------------------------------------------------------
// Capture period speed meter package
// Widths, register map, reset values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package cpsm_pkg;

	localparam int TIMER_BITS = 16;
	localparam int NUM_W      = 24;
	localparam int MINP_W     = 16;
	localparam int STOP_W     = 8;
	localparam int CAP_W      = 16;
	localparam int PERIOD_W   = TIMER_BITS + 1;
	localparam int CMP_W      = (PERIOD_W > MINP_W) ? PERIOD_W : MINP_W;
	localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;
	localparam int REG_IDX_W  = 2;

	localparam logic [REG_IDX_W-1:0] REG_NUMERATOR  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MIN_PERIOD = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_STOP_TICKS = 2'd2;

	localparam logic ACT_CAPTURE = 1'b0;
	localparam logic ACT_TICK    = 1'b1;

	localparam logic [NUM_W-1:0]  RST_NUMERATOR  = NUM_W'(300000);
	localparam logic [MINP_W-1:0] RST_MIN_PERIOD = MINP_W'(100);
	localparam logic [STOP_W-1:0] RST_STOP_TICKS = STOP_W'(20);

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [PERIOD_W-1:0]   period_t;
	typedef logic [NUM_W-1:0]      speed_t;

	typedef struct packed {
		logic [NUM_W-1:0]  numerator;
		logic [MINP_W-1:0] min_period;
		logic [STOP_W-1:0] stop_ticks;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

[sv/cpsm_regs.sv]
// ----------------------------------------------------------------------------
// Capture period speed meter: configuration registers
// APB-style write/read of numerator, minimum period and stop tick limit.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsm_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cpsm_pkg::ADDR_W-1:0] paddr,
	input  logic [cpsm_pkg::DATA_W-1:0] pwdata,
	output logic [cpsm_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output cpsm_pkg::cfg_t             cfg
);
	import cpsm_pkg::*;

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.numerator  <= RST_NUMERATOR;
			cfg_q.min_period <= RST_MIN_PERIOD;
			cfg_q.stop_ticks <= RST_STOP_TICKS;
		end else if (wr_en) begin
			case (idx)
				REG_NUMERATOR:  cfg_q.numerator  <= pwdata[NUM_W-1:0];
				REG_MIN_PERIOD: cfg_q.min_period <= pwdata[MINP_W-1:0];
				REG_STOP_TICKS: cfg_q.stop_ticks <= pwdata[STOP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_NUMERATOR:  prdata = DATA_W'(cfg_q.numerator);
			REG_MIN_PERIOD: prdata = DATA_W'(cfg_q.min_period);
			REG_STOP_TICKS: prdata = DATA_W'(cfg_q.stop_ticks);
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[sv/cpsm_div.sv]
// ----------------------------------------------------------------------------
// Capture period speed meter: restoring divider
// One quotient bit per cycle; quotient shifts into the dividend register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsm_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  cpsm_pkg::speed_t      num,
	input  cpsm_pkg::period_t     den,
	output cpsm_pkg::speed_t      quot,
	output cpsm_pkg::div_stat_t   stat
);
	import cpsm_pkg::*;

	speed_t               num_q;
	period_t              den_q;
	period_t              rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;

	logic [PERIOD_W:0] shifted;
	logic [PERIOD_W:0] diff;
	logic              ge;

	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				cnt_q <= DIV_CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign quot      = num_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule

`default_nettype wire

[sv/capture_period_speed_meter_core.sv]
// ----------------------------------------------------------------------------
// Capture period speed meter core
// Tachometer on a free-running capture timer: speed = numerator / period,
// glitch rejection below a minimum period, forced zero after idle ticks.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake          | Payload
// in      | in  | in_valid/in_stall  | action, capture_value
// out     | out | out_valid/out_stall| speed, accepted, stopped
// cfg     | in  | psel/penable/pready| paddr, pwdata, prdata
//
// Tick or rejected capture: taken in IDLE, evaluated in EVAL, result registered in OUT.
// Accepted capture: EVAL starts the 24-step restoring divider, DIV waits, then OUT.
// One item in flight; in_stall is high until the result is registered.
// A waiting result does not block the next item; out_stall only delays OUT.
// arst_n clears state, held speed to zero and registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "capture_period_speed_meter_core_assert.svh"

module capture_period_speed_meter_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cpsm_pkg::ADDR_W-1:0] paddr,
	input  logic [cpsm_pkg::DATA_W-1:0] pwdata,
	output logic [cpsm_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        action,
	input  logic [cpsm_pkg::CAP_W-1:0]  capture_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [cpsm_pkg::NUM_W-1:0]  speed,
	output logic                        accepted,
	output logic                        stopped
);
	import cpsm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t            state_q;
	cfg_t              cfg;
	div_stat_t         div_stat;
	speed_t            div_quot;
	logic              div_start;

	logic              action_q;
	timer_t            cap_q;
	timer_t            last_q;
	logic [STOP_W-1:0] idle_q;
	speed_t            speed_q;
	logic              acc_q;
	logic              stop_q;

	logic              out_valid_q;
	speed_t            speed_o_q;
	logic              acc_o_q;
	logic              stop_o_q;

	timer_t            diff_raw;
	period_t           period;
	logic              period_ok;
	logic [STOP_W-1:0] idle_inc;
	logic              tick_stop;
	logic              in_take;
	logic              out_free;

	cpsm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cpsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (cfg.numerator),
		.den    (period),
		.quot   (div_quot),
		.stat   (div_stat)
	);

	assign diff_raw  = cap_q - last_q;
	assign period    = {(diff_raw == '0), diff_raw};
	assign period_ok = CMP_W'(period) >= CMP_W'(cfg.min_period);
	assign idle_inc  = idle_q + STOP_W'(1);
	assign tick_stop = idle_inc >= cfg.stop_ticks;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign div_start = (state_q == ST_EVAL) && (action_q == ACT_CAPTURE) && period_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= '0;
			idle_q      <= '0;
			speed_q     <= '0;
			acc_q       <= 1'b0;
			stop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					acc_q  <= (action_q == ACT_CAPTURE) && period_ok;
					stop_q <= (action_q == ACT_TICK) && tick_stop;
					if (action_q == ACT_TICK) begin
						state_q <= ST_OUT;
						if (tick_stop) begin
							speed_q <= '0;
							idle_q  <= '0;
						end else begin
							idle_q <= idle_inc;
						end
					end else if (period_ok) begin
						last_q  <= cap_q;
						idle_q  <= '0;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						speed_q <= div_quot;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_q <= action;
			cap_q    <= TIMER_BITS'(capture_value);
		end
		if (state_q == ST_OUT && out_free) begin
			speed_o_q <= speed_q;
			acc_o_q   <= acc_q;
			stop_o_q  <= stop_q;
		end
	end

	assign out_valid = out_valid_q;
	assign speed     = speed_o_q;
	assign accepted  = acc_o_q;
	assign stopped   = stop_o_q;

	`CPSM_ASSERT_NOW(a_flags_excl, out_valid, !(accepted && stopped), "accepted and stopped both set")
	`CPSM_ASSERT_NOW(a_stop_zero, out_valid && stopped, speed == '0, "stopped result with nonzero speed")
	`CPSM_ASSERT_NOW(a_div_in_div, div_stat.done, state_q == ST_DIV, "divider done outside DIV")
	`CPSM_ASSERT_NOW(a_div_live, state_q == ST_DIV, div_stat.busy || div_stat.done, "DIV with idle divider")
	`CPSM_ASSERT_NEXT(a_start_div, div_start, state_q == ST_DIV && div_stat.busy, "divide did not start")

endmodule

`default_nettype wire
